// ----- sv/rcfe_pkg.sv -----
// rcfe_pkg: shared constants, command word type and CRC-8 helper for the
// RC channel frame encoder. No dependencies.
`default_nettype none

package rcfe_pkg;

    localparam logic [7:0]  FRAME_SYNC   = 8'hC8;
    localparam logic [7:0]  FRAME_LEN    = 8'd24;
    localparam logic [7:0]  TYPE_BYTE    = 8'h16;
    localparam logic [7:0]  CRC_POLY     = 8'hD5;

    localparam logic [11:0] US_MIN       = 12'd988;
    localparam logic [11:0] US_MAX       = 12'd2012;
    localparam logic [11:0] US_MID       = 12'd1500;

    localparam logic [10:0] TICK_MID     = 11'd992;
    localparam logic [10:0] TICK_MIN     = 11'd172;
    localparam logic [10:0] TICK_MAX     = 11'd1811;

    // floor(m / 5) == (m * 3277) >> 14 for every m up to 4096
    localparam logic [11:0] RECIP_DIV5   = 12'd3277;
    localparam int          RECIP_SHIFT  = 14;

    localparam logic [3:0]  LAST_CHANNEL = 4'd15;

    localparam int          CMD_QUEUE_DEPTH = 4;

    // Front-to-back command: payload bytes of one channel plus framing flags
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       first;
        logic       last;
    } cmd_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [7:0]  CRC_AFTER_TYPE = crc_feed(8'h00, TYPE_BYTE);

endpackage

`default_nettype wire

// ----- sv/rcfe_front.sv -----
// rcfe_front: accepts pulse widths, converts them to 11-bit ticks in two
// stages and packs them into payload bytes. Depends on rcfe_pkg.
`default_nettype none

module rcfe_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [11:0]   pulse_us,
    input  wire logic          push,
    output logic               full,
    output rcfe_pkg::cmd_t     cmd,
    output logic               cmd_push,
    input  wire logic          cmd_full
);
    import rcfe_pkg::*;

    logic [11:0] us_clamped;
    logic        below_mid;
    logic [9:0]  mag;
    logic [12:0] mag_x8;

    logic        a_valid_reg, a_valid_next;
    logic [24:0] prod_reg;
    logic        neg_reg;

    logic [9:0]  quot;
    logic [10:0] ticks_raw;
    logic [10:0] ticks;
    logic [17:0] pk;
    logic        two;
    logic        a_load;
    logic        b_go;

    logic [3:0]  pos_reg, pos_next;
    logic [6:0]  res_bits_reg, res_bits_next;
    logic [2:0]  res_cnt_reg, res_cnt_next;

    // stage A: clamp, distance from center, scaled by 8/5 through reciprocal
    always_comb
    begin
        if (pulse_us < US_MIN)
            us_clamped = US_MIN;
        else if (pulse_us > US_MAX)
            us_clamped = US_MAX;
        else
            us_clamped = pulse_us;
        below_mid = us_clamped < US_MID;
        if (below_mid)
            mag = 10'(US_MID - us_clamped);
        else
            mag = 10'(us_clamped - US_MID);
        mag_x8 = {mag, 3'b000};
    end

    assign a_load   = push && !full;
    assign b_go     = a_valid_reg && !cmd_full;
    assign full     = a_valid_reg && cmd_full;
    assign cmd_push = b_go;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
            a_valid_next = 1'b1;
        else if (b_go)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            prod_reg <= 25'(mag_x8) * 25'(RECIP_DIV5);
            neg_reg  <= below_mid;
        end
    end

    // stage B: ticks, clamp, LSB-first packing
    always_comb
    begin
        quot = prod_reg[RECIP_SHIFT +: 10];
        if (neg_reg)
            ticks_raw = TICK_MID - 11'(quot);
        else
            ticks_raw = TICK_MID + 11'(quot);
        if (ticks_raw < TICK_MIN)
            ticks = TICK_MIN;
        else if (ticks_raw > TICK_MAX)
            ticks = TICK_MAX;
        else
            ticks = ticks_raw;

        pk  = {11'b0, res_bits_reg} | ({7'b0, ticks} << res_cnt_reg);
        two = res_cnt_reg >= 3'd5;

        cmd.byte0 = pk[7:0];
        cmd.byte1 = pk[15:8];
        cmd.two   = two;
        cmd.first = pos_reg == 4'd0;
        cmd.last  = pos_reg == LAST_CHANNEL;

        pos_next      = pos_reg;
        res_bits_next = res_bits_reg;
        res_cnt_next  = res_cnt_reg;
        if (b_go)
        begin
            if (pos_reg == LAST_CHANNEL)
            begin
                pos_next      = 4'd0;
                res_bits_next = 7'd0;
                res_cnt_next  = 3'd0;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                if (two)
                begin
                    res_bits_next = {5'b0, pk[17:16]};
                    res_cnt_next  = res_cnt_reg - 3'd5;
                end
                else
                begin
                    res_bits_next = pk[14:8];
                    res_cnt_next  = res_cnt_reg + 3'd3;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            pos_reg      <= 4'd0;
            res_bits_reg <= 7'd0;
            res_cnt_reg  <= 3'd0;
        end
        else
        begin
            a_valid_reg  <= a_valid_next;
            pos_reg      <= pos_next;
            res_bits_reg <= res_bits_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rcfe_cmd_queue.sv -----
// rcfe_cmd_queue: short register queue of command words between front and
// back. Depends on rcfe_pkg.
`default_nettype none

module rcfe_cmd_queue #(
    parameter int DEPTH = rcfe_pkg::CMD_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire rcfe_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output rcfe_pkg::cmd_t     rd_data,
    output logic               valid
);
    import rcfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign valid   = count_reg != '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rcfe_back.sv -----
// rcfe_back: walks each command out one frame byte per unstalled cycle (header,
// payload, CRC), keeps the running CRC, holds the output word. Depends on rcfe_pkg.
`default_nettype none

module rcfe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rcfe_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    output logic [7:0]         frame_byte,
    output logic               last_in_run,
    output logic               end_of_frame,
    output logic               empty,
    input  wire logic          pop
);
    import rcfe_pkg::*;

    logic [2:0] step_reg, step_next;
    logic [7:0] crc_reg, crc_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] frame_byte_reg;
    logic       last_reg;
    logic       eof_reg;

    logic [2:0] hdr_len;
    logic [2:0] pay_len;
    logic [2:0] total;
    logic [2:0] pidx;
    logic [7:0] cur_byte;
    logic       cur_eof;
    logic       cur_last;
    logic       is_type;
    logic       is_pay;
    logic       emit;

    always_comb
    begin
        hdr_len  = cmd.first ? 3'd3 : 3'd0;
        pay_len  = cmd.two ? 3'd2 : 3'd1;
        total    = hdr_len + pay_len + {2'b0, cmd.last};
        pidx     = step_reg - hdr_len;
        cur_last = step_reg == total - 3'd1;
        is_type  = 1'b0;
        is_pay   = 1'b0;
        cur_eof  = 1'b0;
        if (cmd.first && step_reg < 3'd3)
        begin
            case (step_reg)
                3'd0:    cur_byte = FRAME_SYNC;
                3'd1:    cur_byte = FRAME_LEN;
                default:
                begin
                    cur_byte = TYPE_BYTE;
                    is_type  = 1'b1;
                end
            endcase
        end
        else if (pidx < pay_len)
        begin
            cur_byte = pidx[0] ? cmd.byte1 : cmd.byte0;
            is_pay   = 1'b1;
        end
        else
        begin
            cur_byte = crc_reg;
            cur_eof  = 1'b1;
        end
    end

    assign emit    = cmd_valid && (!out_valid_reg || pop);
    assign cmd_pop = emit && cur_last;

    always_comb
    begin
        step_next      = step_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = cur_last ? 3'd0 : step_reg + 3'd1;
            if (is_type)
                crc_next = CRC_AFTER_TYPE;
            else if (is_pay)
                crc_next = crc_feed(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frame_byte_reg <= cur_byte;
            last_reg       <= cur_last;
            eof_reg        <= cur_eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            crc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign frame_byte   = frame_byte_reg;
    assign last_in_run  = last_reg;
    assign end_of_frame = eof_reg;
    assign empty        = !out_valid_reg;

    a_eof_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && eof_reg |-> last_reg)
        else $error("CRC word not marked last of its run");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd5)
        else $error("byte step beyond longest command");

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command released while queue empty");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> step_reg == 3'd0)
        else $error("step not rewound after command");

endmodule

`default_nettype wire

// ----- sv/rc_channel_frame_encoder.sv -----
// Channel  | Handshake              | Words
// ---------+------------------------+---------------------------------------------
// input    | push / full            | pulse_us[11:0]
// result   | empty / pop            | frame_byte[7:0], last_in_run, end_of_frame
//
// Front takes one pulse per cycle unless full (two-stage tick conversion) into a
// command queue. Back emits one frame byte per cycle unless pop stalls: 26 bytes per
// 16 channels. A pulse passes stage A, the queue and the back's output register.
// Reset clears the frame position, residual bits, CRC and all queues.
// A stalled pop backs up through the back, the command queue and then asserts full.
// rc_channel_frame_encoder: top level. Depends on rcfe_pkg, rcfe_front,
// rcfe_cmd_queue and rcfe_back.
`default_nettype none

module rc_channel_frame_encoder #(
    parameter int QUEUE_DEPTH = rcfe_pkg::CMD_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [11:0] pulse_us,
    input  wire logic        push,
    output logic             full,
    output logic [7:0]       frame_byte,
    output logic             last_in_run,
    output logic             end_of_frame,
    output logic             empty,
    input  wire logic        pop
);
    import rcfe_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_valid;
    logic back_pop;

    rcfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pulse_us (pulse_us),
        .push     (push),
        .full     (full),
        .cmd      (front_cmd),
        .cmd_push (front_push),
        .cmd_full (queue_full)
    );

    rcfe_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (queue_full),
        .rd_en   (back_pop),
        .rd_data (queue_cmd),
        .valid   (queue_valid)
    );

    rcfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (queue_cmd),
        .cmd_valid    (queue_valid),
        .cmd_pop      (back_pop),
        .frame_byte   (frame_byte),
        .last_in_run  (last_in_run),
        .end_of_frame (end_of_frame),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

`default_nettype wire
